FILE: design/srs_pkg.sv
// Shared types and constants for the secant root search block.
`default_nettype none
package srs_pkg;
  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam logic [7:0]  MAX_ITER_RST  = 8'd20;
  localparam logic [30:0] TOL_RST       = 31'd168;
  localparam logic [30:0] MAX_STEP_RST  = 31'd41943040;
  localparam logic [30:0] MIN_SPR_RST   = 31'd17;

  localparam logic [1:0] REG_MAX_ITER = 2'd0;
  localparam logic [1:0] REG_TOL      = 2'd1;
  localparam logic [1:0] REG_MAX_STEP = 2'd2;
  localparam logic [1:0] REG_MIN_SPR  = 2'd3;

  localparam int unsigned DIV_W = 64;
  localparam int unsigned CNT_W = 7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPDATE, ST_MUL1, ST_MUL2, ST_DIV, ST_GUESS, ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic update;
    logic mul1;
    logic div_start;
    logic div_step;
    logic guess;
    logic out_valid;
  } srs_cmd_t;

  typedef struct packed {
    logic div_done;
  } srs_sts_t;
endpackage
`default_nettype wire

FILE: design/srs_ctrl.sv
// Controller state machine for the secant root search.
`default_nettype none
module srs_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_ready,
  input  wire srs_pkg::srs_sts_t sts,
  output srs_pkg::srs_cmd_t cmd
);
  import srs_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_DIV;
      ST_DIV:    if (sts.div_done) state_nxt = ST_GUESS;
      ST_GUESS:  state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE:   begin in_ready = 1'b1; cmd.load_in = in_valid; end
      ST_UPDATE: cmd.update = 1'b1;
      ST_MUL1:   cmd.mul1 = 1'b1;
      ST_MUL2:   cmd.div_start = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_GUESS:  cmd.guess = 1'b1;
      ST_OUT:    cmd.out_valid = 1'b1;
      default:   cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/srs_dp.sv
// Datapath: point registers, update rules, multiplier and serial divider.
`default_nettype none
module srs_dp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_mode,
  input  wire logic signed [31:0] in_first_x,
  input  wire logic signed [31:0] in_first_err,
  input  wire logic signed [31:0] in_second_x,
  input  wire logic signed [31:0] in_second_err,
  input  wire srs_pkg::srs_cmd_t cmd,
  output srs_pkg::srs_sts_t sts,
  output logic        out_stop,
  output logic        out_gave_up,
  output logic signed [31:0] out_next_guess
);
  import srs_pkg::*;

  logic [7:0]  max_iter_r;
  logic [30:0] tol_r, max_step_r, min_spr_r;
  logic signed [31:0] ax_r, ae_r, bx_r, be_r, ref_r;
  logic [7:0] cnt_r;
  logic final_r;
  logic mode_r;
  logic signed [31:0] x_r, e_r, x2_r, e2_r;
  logic stop_r, gave_r;
  logic [31:0] m1a_r, m1b_r;
  logic [32:0] dmag_r;
  logic dneg_r, dzero_r;
  logic [DIV_W-1:0] quo_r;
  logic [33:0] rem_r;
  logic [CNT_W-1:0] dcnt_r;
  logic signed [31:0] guess_r;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST; tol_r <= TOL_RST;
      max_step_r <= MAX_STEP_RST; min_spr_r <= MIN_SPR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ITER: max_iter_r <= cfg_data[7:0];
        REG_TOL:      tol_r <= cfg_data;
        REG_MAX_STEP: max_step_r <= cfg_data;
        REG_MIN_SPR:  min_spr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // convergence / replacement decision
  logic [31:0] me, ma, mb, mref;
  logic [62:0] tolp;
  logic [63:0] lhs;
  logic conv, give, take_a, take_b;
  logic [7:0] cnt_inc;
  logic [32:0] spread;
  logic sgn_ab, opp_ae, opp_be;
  always_comb begin
    me = 32'(mag33(33'(e_r)));
    ma = 32'(mag33(33'(ae_r)));
    mb = 32'(mag33(33'(be_r)));
    mref = 32'(mag33(33'(ref_r)));
    tolp = 63'(tol_r) * 63'(mref);
    lhs = 64'(me) << FRAC_BITS_DEF;
    conv = (me < 32'(tol_r)) || (tolp != '0 && lhs < 64'(tolp));
    cnt_inc = (cnt_r != 8'd255) ? cnt_r + 8'd1 : cnt_r;
    spread = mag33(33'(ax_r) - 33'(bx_r));
    sgn_ab = (ae_r > 0 && be_r > 0) || (ae_r < 0 && be_r < 0);
    opp_ae = (ae_r > 0 && e_r < 0) || (ae_r < 0 && e_r > 0);
    opp_be = (be_r > 0 && e_r < 0) || (be_r < 0 && e_r > 0);
    give = 1'b0; take_a = 1'b0; take_b = 1'b0;
    if (cnt_inc >= max_iter_r || spread < 33'(min_spr_r)) give = 1'b1;
    else if (ma > me && ma > mb) take_a = 1'b1;
    else if (mb > me && mb > ma) take_b = 1'b1;
    else if (sgn_ab) begin
      if (opp_ae) take_a = 1'b1;
      else if (opp_be) take_b = 1'b1;
      else give = 1'b1;
    end else give = 1'b1;
  end

  // serial divider step (restoring, 64-bit dividend, 33-bit divisor)
  logic [33:0] rem_sh;
  logic [33:0] rem_sub;
  always_comb begin
    rem_sh = {rem_r[32:0], quo_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dmag_r};
  end

  logic signed [32:0] dx, de;
  logic signed [33:0] msum;
  logic signed [31:0] mid;
  logic [DIV_W-1:0] qm;
  logic signed [65:0] g;
  always_comb begin
    dx = 33'(ax_r) - 33'(bx_r);
    de = 33'(ae_r) - 33'(be_r);
    msum = 34'(ax_r) + 34'(bx_r);
    mid = 32'(msum >>> 1);
    qm = quo_r;
    g = 66'(bx_r) - (dneg_r ? -66'(qm) : 66'(qm));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ae_r <= '0; bx_r <= '0; be_r <= '0; ref_r <= '0;
      cnt_r <= '0; final_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (!mode_r) begin
          ax_r <= x_r; ae_r <= e_r; bx_r <= x2_r; be_r <= e2_r;
          ref_r <= (32'(mag33(33'(e_r))) > 32'(mag33(33'(e2_r)))) ? e2_r : e_r;
          cnt_r <= 8'd1; final_r <= 1'b0;
        end else if (!final_r && !conv) begin
          cnt_r <= cnt_inc;
          if (give) final_r <= 1'b1;
          else if (take_a) begin ax_r <= x_r; ae_r <= e_r; end
          else if (take_b) begin bx_r <= x_r; be_r <= e_r; end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode; x_r <= in_first_x; e_r <= in_first_err;
      x2_r <= in_second_x; e2_r <= in_second_err;
    end
    if (cmd.update) begin
      stop_r <= mode_r && (final_r || conv);
      gave_r <= mode_r && !final_r && !conv && give;
    end
    if (cmd.mul1) begin
      m1a_r <= 32'(mag33(33'(be_r)));
      m1b_r <= 32'(mag33(dx));
      dmag_r <= mag33(de);
      dzero_r <= (de == '0);
      dneg_r <= ((be_r < 0) != dx[32]) != de[32];
    end
    // product loads straight into the dividend/quotient shifter
    if (cmd.div_start) begin
      quo_r <= 64'(m1a_r) * 64'(m1b_r);
      rem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[33]) begin
        rem_r <= rem_sub; quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh; quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + CNT_W'(1);
    end
    if (cmd.guess) begin
      if (dzero_r || qm > (64'd1 << 40) || g < 0 || g > 66'(max_step_r))
        guess_r <= mid;
      else guess_r <= 32'(g);
    end
  end

  assign sts.div_done = cmd.div_step && (dcnt_r == CNT_W'(DIV_W - 1));
  assign out_stop = stop_r;
  assign out_gave_up = gave_r;
  assign out_next_guess = guess_r;
endmodule
`default_nettype wire

FILE: design/secant_root_search_step.sv
// Top level of the secant root search step block.
// A request occupies the block while it passes, in order, the accepting cycle,
// the update, the operand state, a 32x32 multiply, the 64-step bit-serial
// restoring divider that forms |b_err*(a_x-b_x)|/|a_err-b_err|, the guess
// select and the output state. out_valid rises in the output state; the
// divider sets the pace. One request is in flight at a time; the result
// holds until taken and in_ready stays low meanwhile. Configuration writes
// take effect at once and belong between requests.
`default_nettype none
module secant_root_search_step (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic signed [31:0] in_first_x,
  input  wire logic signed [31:0] in_first_err,
  input  wire logic signed [31:0] in_second_x,
  input  wire logic signed [31:0] in_second_err,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_stop,
  output logic             out_gave_up,
  output logic signed [31:0] out_next_guess
);
  import srs_pkg::*;
  srs_cmd_t cmd;
  srs_sts_t sts;

  srs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_ready, .sts, .cmd
  );

  srs_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_mode, .in_first_x, .in_first_err, .in_second_x, .in_second_err,
    .cmd, .sts, .out_stop, .out_gave_up, .out_next_guess
  );

  assign out_valid = cmd.out_valid;
endmodule
`default_nettype wire

FILE: verif/srs_guess_checker.sv
// Checker for the secant root search step: tracks config, predicts each result, compares.
module srs_guess_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_mode,
  input  logic [31:0] in_first_x,
  input  logic [31:0] in_first_err,
  input  logic [31:0] in_second_x,
  input  logic [31:0] in_second_err,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_stop,
  input  logic        out_gave_up,
  input  logic [31:0] out_next_guess,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import srs_pkg::*;

  typedef struct {
    bit          stop;
    bit          gave_up;
    logic [31:0] guess;
  } guess_result_t;

  guess_result_t expected_results[$];

  logic [7:0]  max_iter;
  logic [30:0] tol, max_step, min_spread;
  longint      a_x, a_err, b_x, b_err, ref_err;
  int          iter_cnt;
  bit          final_round;

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint floor_mid();
    return (a_x + b_x) >>> 1;
  endfunction

  function automatic longint secant_guess();
    longint dx, de, q, g;
    longint unsigned qm;
    bit neg;
    dx = a_x - b_x;
    de = a_err - b_err;
    if (de == 0) return floor_mid();
    qm = (abs64(b_err) * abs64(dx)) / abs64(de);
    if (qm > (64'd1 << 40)) return floor_mid();
    neg = ((b_err < 0) != (dx < 0)) != (de < 0);
    q = neg ? -longint'(qm) : longint'(qm);
    g = b_x - q;
    if (g < 0 || g > longint'(max_step)) return floor_mid();
    return g;
  endfunction

  function automatic bit same_sgn(longint p, longint q);
    return (p > 0 && q > 0) || (p < 0 && q < 0);
  endfunction

  function automatic bit opp_sgn(longint p, longint q);
    return (p > 0 && q < 0) || (p < 0 && q > 0);
  endfunction

  function automatic guess_result_t predict_step(bit mode, longint x, longint e,
                                                 longint x2, longint e2);
    guess_result_t r;
    longint unsigned me, ma, mb, prod;
    bit conv, give;
    r.stop = 0;
    r.gave_up = 0;
    if (!mode) begin
      a_x = x; a_err = e; b_x = x2; b_err = e2;
      ref_err = (abs64(a_err) > abs64(b_err)) ? b_err : a_err;
      iter_cnt = 1;
      final_round = 0;
    end else if (final_round) begin
      r.stop = 1;
    end else begin
      me = abs64(e);
      prod = longint'(tol) * abs64(ref_err);
      conv = me < tol;
      // relative test, exact: |e| * 2^24 < tol * |ref|
      if (!conv && prod != 0 && me <= ((prod - 1) >> FRAC_BITS_DEF)) conv = 1;
      if (conv) begin
        r.stop = 1;
      end else begin
        give = 0;
        ma = abs64(a_err);
        mb = abs64(b_err);
        if (iter_cnt < 255) iter_cnt++;
        if (iter_cnt >= max_iter || abs64(a_x - b_x) < min_spread) begin
          give = 1;
        end else if (ma > me && ma > mb) begin
          a_err = e; a_x = x;
        end else if (mb > me && mb > ma) begin
          b_err = e; b_x = x;
        end else if (same_sgn(a_err, b_err)) begin
          if (opp_sgn(a_err, e)) begin
            a_err = e; a_x = x;
          end else if (opp_sgn(b_err, e)) begin
            b_err = e; b_x = x;
          end else begin
            give = 1;
          end
        end else begin
          give = 1;
        end
        if (give) begin
          final_round = 1;
          r.gave_up = 1;
        end
      end
    end
    r.guess = secant_guess();
    return r;
  endfunction

  always @(posedge clk) begin
    guess_result_t exp_r;
    if (!rst_n) begin
      max_iter = MAX_ITER_RST;
      tol = TOL_RST;
      max_step = MAX_STEP_RST;
      min_spread = MIN_SPR_RST;
      a_x = 0; a_err = 0; b_x = 0; b_err = 0; ref_err = 0;
      iter_cnt = 0;
      final_round = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ITER: max_iter = cfg_data[7:0];
          REG_TOL:      tol = cfg_data;
          REG_MAX_STEP: max_step = cfg_data;
          REG_MIN_SPR:  min_spread = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_step(in_mode,
          longint'($signed(in_first_x)), longint'($signed(in_first_err)),
          longint'($signed(in_second_x)), longint'($signed(in_second_err))));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result stop=%0b gave_up=%0b guess=%h", $time,
                   out_stop, out_gave_up, out_next_guess);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_stop !== exp_r.stop) begin
            errors++;
            $display("%0t: stop expected %0b actual %0b", $time, exp_r.stop, out_stop);
          end
          if (out_gave_up !== exp_r.gave_up) begin
            errors++;
            $display("%0t: gave_up expected %0b actual %0b", $time, exp_r.gave_up,
                     out_gave_up);
          end
          if (out_next_guess !== exp_r.guess) begin
            errors++;
            $display("%0t: next_guess expected %h actual %h", $time, exp_r.guess,
                     out_next_guess);
          end
        end
      end
    end
    pending = expected_results.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

FILE: verif/tb_secant_root_search_step.sv
// Testbench top for the secant root search step: stimulus, flow control, verdict.
module tb_secant_root_search_step;
  timeunit 1ns;
  timeprecision 1ps;
  import srs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no request or result moving
  localparam int DRAIN_CYCLES   = 100;    // margin after the last result is back
  localparam int LONG_HOLD      = 400;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = REG_MAX_ITER;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_mode = 0;
  logic signed [31:0] in_first_x = '0, in_first_err = '0;
  logic signed [31:0] in_second_x = '0, in_second_err = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        out_stop, out_gave_up;
  logic signed [31:0] out_next_guess;

  int errors, pending;
  bit idle_en = 1;     // random gaps on both channels
  bit long_hold = 0;   // asks the receiver for one long stall
  int quiet_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  secant_root_search_step u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_mode, .in_first_x, .in_first_err,
    .in_second_x, .in_second_err,
    .out_valid, .out_ready, .out_stop, .out_gave_up, .out_next_guess
  );

  srs_guess_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_mode, .in_first_x, .in_first_err,
    .in_second_x, .in_second_err,
    .out_valid, .out_ready, .out_stop, .out_gave_up, .out_next_guess,
    .errors, .pending
  );

  // Watchdog: any cycle with a handshake on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold-off when asked.
  initial begin
    bit held;
    held = 0;
    @(posedge clk);
    forever begin
      if (long_hold && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(bit mode, logic [31:0] fx, logic [31:0] fe,
                              logic [31:0] sx, logic [31:0] se);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= mode;
    in_first_x <= fx;
    in_first_err <= fe;
    in_second_x <= sx;
    in_second_err <= se;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  // Drop valid and wait until every result is back, plus some margin.
  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Pick a new setting; extremes come up now and then.
  task automatic random_settings();
    case ($urandom_range(0, 5))
      0: write_reg(REG_MAX_ITER, 31'd1);
      1: write_reg(REG_MAX_ITER, 31'd255);
      default: write_reg(REG_MAX_ITER, 31'($urandom_range(3, 30)));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(REG_TOL, 31'h7FFF_FFFF);
      1: write_reg(REG_TOL, 31'd0);
      2: write_reg(REG_TOL, 31'($urandom));
      default: write_reg(REG_TOL, 31'($urandom_range(0, 1 << 20)));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(REG_MAX_STEP, 31'h7FFF_FFFF);
      1: write_reg(REG_MAX_STEP, 31'd0);
      2: write_reg(REG_MAX_STEP, 31'($urandom));
      default: write_reg(REG_MAX_STEP, 31'($urandom_range(1 << 24, 4 << 24)));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(REG_MIN_SPR, 31'h7FFF_FFFF);
      1: write_reg(REG_MIN_SPR, 31'd0);
      2: write_reg(REG_MIN_SPR, 31'($urandom));
      default: write_reg(REG_MIN_SPR, 31'($urandom_range(0, 1 << 12)));
    endcase
  endtask

  // One search: a start request around a root, then points closing in on it.
  // Returns the number of requests sent.
  task automatic run_search(output int sent);
    int root, sh, npts, off;
    logic signed [31:0] x0, x1, px;
    bit flip;
    root = $urandom_range(0, 3 << 24);
    sh = $urandom_range(0, 6);
    flip = 1'($urandom_range(0, 1));
    x0 = root - $urandom_range(1, 1 << 24);
    x1 = root + $urandom_range(1, 1 << 24);
    send_request(0, x0, flip ? -((x0 - root) >>> sh) : (x0 - root) >>> sh,
                 x1, flip ? -((x1 - root) >>> sh) : (x1 - root) >>> sh);
    npts = $urandom_range(1, 12);
    for (int k = 0; k < npts; k++) begin
      off = $urandom_range(0, 1 << 24) >> (2 * k);
      px = $urandom_range(0, 1) ? root + off : root - off;
      send_request(1, px, flip ? -((px - root) >>> sh) : (px - root) >>> sh, 0, 0);
    end
    sent = npts + 1;
  endtask

  initial begin
    int sent, total;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: point request straight after reset works on the zero state
    // and gives up on the zero spread; the next one sees the final round.
    send_request(1, 32'h1234_5678, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1, 32'h8000_0000, 32'h8000_0000, 0, 0);
    // Field extremes on a start
    send_request(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_request(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    // Zero reference error: relative test must not fire
    send_request(0, 32'h0100_0000, 0, 32'h0200_0000, 32'h0050_0000);
    send_request(1, 32'h0180_0000, 32'd1000, 0, 0);
    // Equal errors: zero denominator, midpoint
    send_request(0, 32'h0100_0000, 32'h0010_0000, 32'h0200_0000, 32'h0010_0000);
    // Bracketed start, then converge on absolute tolerance
    send_request(0, 32'h0100_0000, -32'sh0040_0000, 32'h0200_0000, 32'h0040_0000);
    send_request(1, 32'h0180_0000, 32'd100, 0, 0);
    // Same-sign start: replacement by sign, then give-up on a matching sign
    send_request(0, 32'h0100_0000, 32'h0040_0000, 32'h0200_0000, 32'h0040_0000);
    send_request(1, 32'h0140_0000, -32'sh0020_0000, 0, 0);
    send_request(1, 32'h0150_0000, 32'h0040_0000, 0, 0);
    // An in-range guess, then a guess above max_step that falls back to the midpoint
    send_request(0, 32'h0000_1000, 32'h0100_0000, 32'h0000_2000, 32'h0080_0000);
    send_request(0, 32'h0200_0000, -32'sh0100_0000, 32'h0280_0000, -32'sh0080_0000);
    // Spread below min_spread
    send_request(0, 32'h0100_0000, 32'h0100_0000, 32'h0100_0008, -32'sh0100_0000);
    send_request(1, 32'h0100_0004, 32'h0000_1000, 0, 0);
    drain();

    // Zero iteration limit: every unconverged point gives up
    write_reg(REG_MAX_ITER, 31'd0);
    write_reg(REG_TOL, 31'h7FFF_FFFF);
    write_reg(REG_MAX_STEP, 31'h7FFF_FFFF);
    write_reg(REG_MIN_SPR, 31'd0);
    send_request(0, 32'h0100_0000, -32'sh0040_0000, 32'h0200_0000, 32'h0040_0000);
    send_request(1, 32'h0180_0000, 32'h7FFF_FFFF, 0, 0);
    send_request(1, 32'h0180_0000, 32'd1, 0, 0);
    drain();
    write_reg(REG_MAX_ITER, 31'd255);
    write_reg(REG_TOL, 31'd0);
    send_request(0, 32'h0100_0000, -32'sh0040_0000, 32'h0200_0000, 32'h0040_0000);
    for (int k = 0; k < 4; k++)
      send_request(1, 32'h0140_0000 + k, -32'sh0001_0000 + k, 0, 0);
    drain();

    // Random phases. Each ends in a drain, so the sender also waits on
    // every outstanding result before the next setting goes in.
    total = 0;
    for (int phase = 0; phase < 8; phase++) begin
      random_settings();
      if (phase == 2) long_hold = 1;
      if (phase == 7) idle_en = 0;
      for (int n = 0; n < 100; n += sent) begin
        if ($urandom_range(0, 4) != 0) begin
          run_search(sent);
        end else begin
          send_request(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
          sent = 1;
        end
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
